// File: rtl/abas_pkg.sv
`timescale 1ns / 1ps

package abas_pkg;

  localparam int WINDOW_LEN  = 40;
  localparam int READING_W   = 10;
  localparam int LEVEL_W     = 4;
  localparam int SUM_W       = 10;
  localparam int SCALE_MUL   = 15;
  localparam int SCALE_SHIFT = 10;
  localparam int PROD_W      = READING_W + LEVEL_W;

  // reciprocal of the window length, exact for every sum below 2**SUM_W
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int MEAN_W      = SUM_W + RECIP_W;

  localparam logic [LEVEL_W-1:0] RESET_LEVEL = LEVEL_W'(2);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [READING_W-1:0] light_reading;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic [LEVEL_W-1:0] target_level;
    logic               brightness_changed;
  } out_item_t;

  // reading * 15 / 1024, truncated
  function automatic logic [LEVEL_W-1:0] scale_level(input logic [READING_W-1:0] reading);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(reading) * PROD_W'(SCALE_MUL);
    return prod[SCALE_SHIFT +: LEVEL_W];
  endfunction

  // sum / WINDOW_LEN by reciprocal multiply, low level bits kept
  function automatic logic [LEVEL_W-1:0] mean_level(input logic [SUM_W-1:0] sum);
    logic [MEAN_W-1:0] prod;
    prod = MEAN_W'(sum) * MEAN_W'(RECIP);
    return prod[RECIP_SHIFT +: LEVEL_W];
  endfunction

endpackage

// File: rtl/ambient_brightness_average_slew.sv
`timescale 1ns / 1ps

// Ambient brightness smoother. A sample transfer scales a 10-bit light reading
// to a level 0..14 (reading * 15 / 1024), pushes it into a 40-deep window that
// reset fills with zeros, and sets the target to the truncated mean of the
// whole window. A step transfer moves the display brightness one level toward
// the target. Target and brightness both come out of reset at two. Every input
// transfer yields exactly one result transfer carrying brightness, target and a
// changed flag. One item per clock is taken while out_ready does not stall the
// output; a result passes through one input register and one output register,
// with the running-sum update, the reciprocal divide and the slew step done in
// the single logic pass between them.

module ambient_brightness_average_slew import abas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // input register
  in_item_t in_r;
  logic     in_valid_r;

  // output register
  out_item_t out_r;
  logic      out_valid_r;

  logic               advance;
  logic               sample_en;
  logic               step_en;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] target_cur;
  logic [LEVEL_W-1:0] target_nxt;
  logic [LEVEL_W-1:0] brightness_nxt;
  logic               changed;

  // held item moves on when the output register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || !out_valid_r || out_ready;
  assign sample_en = advance && (in_r.operation == OP_SAMPLE);
  assign step_en   = advance && (in_r.operation == OP_STEP);
  assign level     = scale_level(in_r.light_reading);

  // window of levels with running sum and target
  abas_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_en    (sample_en),
    .level_in     (level),
    .target_o     (target_cur),
    .target_nxt_o (target_nxt)
  );

  // brightness slew toward the current target
  abas_slew u_slew (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (step_en),
    .target           (target_cur),
    .brightness_nxt_o (brightness_nxt),
    .changed_o        (changed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.brightness         <= brightness_nxt;
      out_r.target_level       <= target_nxt;
      out_r.brightness_changed <= changed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/abas_window.sv
`timescale 1ns / 1ps

module abas_window import abas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sample_en,
  input  logic [LEVEL_W-1:0] level_in,
  output logic [LEVEL_W-1:0] target_o,
  output logic [LEVEL_W-1:0] target_nxt_o
);

  logic [LEVEL_W-1:0] taps_r [WINDOW_LEN];
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [LEVEL_W-1:0] target_r;

  // oldest level drops out at the end of the shift line
  assign sum_nxt = sum_r - SUM_W'(taps_r[WINDOW_LEN-1]) + SUM_W'(level_in);
  assign target_nxt_o = sample_en ? mean_level(sum_nxt) : target_r;
  assign target_o = target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps_r[i] <= '0;
      end
      sum_r    <= '0;
      target_r <= RESET_LEVEL;
    end else if (sample_en) begin
      taps_r[0] <= level_in;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
      sum_r    <= sum_nxt;
      target_r <= target_nxt_o;
    end
  end

endmodule

// File: rtl/abas_slew.sv
`timescale 1ns / 1ps

module abas_slew import abas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [LEVEL_W-1:0] target,
  output logic [LEVEL_W-1:0] brightness_nxt_o,
  output logic               changed_o
);

  logic [LEVEL_W-1:0] brightness_r;

  always_comb begin
    brightness_nxt_o = brightness_r;
    changed_o        = 1'b0;
    if (step_en) begin
      if (brightness_r < target) begin
        brightness_nxt_o = brightness_r + LEVEL_W'(1);
        changed_o        = 1'b1;
      end else if (brightness_r > target) begin
        brightness_nxt_o = brightness_r - LEVEL_W'(1);
        changed_o        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= RESET_LEVEL;
    end else begin
      brightness_r <= brightness_nxt_o;
    end
  end

endmodule
